FILE: rtl/dwwp_pkg.sv
// Shared types, constants and weighting helpers for the waypoint picker.
// No dependencies.
package dwwp_pkg;
  localparam int MaxPoints = 64;
  localparam int SlotW = $clog2(MaxPoints);
  localparam int CoordW = 24;
  localparam int PointW = 3 * CoordW;

  localparam logic [1:0] ST_SELECTED = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  localparam logic OP_INSERT = 1'b0;

  function automatic logic [31:0] root_const(input logic [2:0] k);
    logic [31:0] v;
    case (k)
      3'd0: v = 32'd1076653033;
      3'd1: v = 32'd1079572136;
      3'd2: v = 32'd1085434106;
      3'd3: v = 32'd1097253708;
      3'd4: v = 32'd1121280436;
      3'd5: v = 32'd1170923762;
      3'd6: v = 32'd1276901417;
      default: v = 32'd1518500250;
    endcase
    return v;
  endfunction
endpackage

FILE: rtl/dwwp_ram.sv
// Generic single-port write, single-port read RAM with registered read data.
// No dependencies.
module dwwp_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/dwwp_weight.sv
// Multi-cycle weight unit: squared distance in, round(2^(24-E)) out.
// Uses dwwp_pkg; one squaring or root product per cycle.
module dwwp_weight (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [49:0] dist_sq,
  input  logic [7:0]  degree,
  output logic        done,
  output logic [31:0] weight
);
  import dwwp_pkg::*;

  typedef enum logic [5:0] {
    W_IDLE = 6'b000001,
    W_LOG  = 6'b000010,
    W_EXP  = 6'b000100,
    W_ROOT = 6'b001000,
    W_SHFT = 6'b010000,
    W_DONE = 6'b100000
  } wstate_t;

  wstate_t state_r, state_nxt;
  logic [5:0]  p_r;
  logic [16:0] x_r;
  logic [7:0]  fr_r;
  logic [3:0]  k_r;
  logic signed [20:0] g_r;
  logic [31:0] m_r;
  logic [31:0] weight_r;

  logic [5:0]  p_c;
  logic [7:0]  idx_c;
  logic [33:0] sq_c;
  logic [16:0] sq_t;
  logic signed [15:0] ld_c;
  logic signed [24:0] e_c;
  logic [63:0] mp_c;
  logic signed [11:0] n_c;
  logic signed [12:0] s_c;
  logic [63:0] sh_c;

  always_comb begin
    p_c = '0;
    for (int b = 0; b < 50; b++) begin
      if (dist_sq[b]) p_c = 6'(b);
    end
    if (p_c >= 6'd8) idx_c = 8'(dist_sq >> (p_c - 6'd8));
    else idx_c = 8'(dist_sq << (6'd8 - p_c));
  end

  assign sq_c = 34'(x_r) * 34'(x_r);
  assign sq_t = 17'(sq_c >> 15);
  assign ld_c = (16'(signed'({1'b0, p_r})) - 16'sd16) * 16'sd256
                + 16'(signed'({1'b0, fr_r}));
  assign e_c = (25'(signed'({1'b0, degree})) * 25'(ld_c) + 25'sd16) >>> 5;
  assign mp_c = 64'(m_r) * 64'(root_const(k_r[2:0])) + 64'(32'd1 << 29);
  assign n_c = 12'(g_r >>> 8);
  assign s_c = 13'sd30 - 13'(n_c);
  assign sh_c = 64'(m_r) + (64'd1 << (s_c - 13'sd1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      W_IDLE: if (start) state_nxt = W_LOG;
      W_LOG:  if (k_r == 4'd7) state_nxt = W_EXP;
      W_EXP:  state_nxt = W_ROOT;
      W_ROOT: if (k_r == 4'd7) state_nxt = W_SHFT;
      W_SHFT: state_nxt = W_DONE;
      W_DONE: state_nxt = W_IDLE;
      default: state_nxt = W_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= W_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    case (state_r)
      W_IDLE: begin
        p_r <= p_c;
        x_r <= {1'b0, 1'b1, idx_c, 7'd0};
        fr_r <= '0;
        k_r <= '0;
      end
      W_LOG: begin
        k_r <= k_r + 4'd1;
        if (sq_t[16]) begin
          fr_r <= {fr_r[6:0], 1'b1};
          x_r <= sq_t >> 1;
        end else begin
          fr_r <= {fr_r[6:0], 1'b0};
          x_r <= sq_t;
        end
      end
      W_EXP: begin
        g_r <= 21'(25'sd6144 - e_c);
        m_r <= 32'd1 << 30;
        k_r <= '0;
      end
      W_ROOT: begin
        k_r <= k_r + 4'd1;
        if (g_r[k_r[2:0]]) m_r <= 32'(mp_c >> 30);
      end
      W_SHFT: begin
        if (n_c >= 12'sd32) weight_r <= '1;
        else if (s_c <= 0) begin
          if ((64'(m_r) << (-s_c)) > 64'hFFFF_FFFF) weight_r <= '1;
          else weight_r <= 32'(64'(m_r) << (-s_c));
        end else if (s_c >= 13'sd32) weight_r <= '0;
        else weight_r <= 32'(sh_c >> s_c);
      end
      default: ;
    endcase
  end

  assign done = (state_r == W_DONE);
  assign weight = weight_r;
endmodule

FILE: rtl/distance_weighted_waypoint_picker.sv
// Top level of the waypoint picker: slot sequencer over point and weight RAMs.
// Depends on dwwp_pkg, dwwp_ram, dwwp_weight.
//
//  channel | ports                                  | direction
//  in      | in_valid in_stall in_operation in_pos_* | consumer
//  out     | out_valid out_stall out_status out_*    | producer
//  cfg     | cfg_we cfg_planning_degree              | write only
//
// Insert: result registered the cycle after the input transaction.
// Select: a weighting pass over all slots, in which each valid slot's weight
// is computed by the weight unit, then a search pass that accumulates the
// weights of the valid slots against a random threshold to pick the result.
// Reset clears valid bits and control state; RAM contents stay undefined.
// One item in flight; in_stall holds until the result transaction is taken.
module distance_weighted_waypoint_picker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_planning_degree,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic signed [23:0] in_pos_x,
  input  logic signed [23:0] in_pos_y,
  input  logic signed [23:0] in_pos_z,
  input  logic [15:0] in_random_fraction,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic signed [23:0] out_out_x,
  output logic signed [23:0] out_out_y,
  output logic signed [23:0] out_out_z,
  output logic [5:0]  out_out_slot
);
  import dwwp_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_WREAD = 9'b000000010,
    S_WDIST = 9'b000000100,
    S_WCALC = 9'b000001000,
    S_THR   = 9'b000010000,
    S_SREAD = 9'b000100000,
    S_SACC  = 9'b001000000,
    S_FETCH = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r;
  logic [7:0] degree_r;
  logic [MaxPoints-1:0] valid_r;
  logic signed [23:0] px_r, py_r, pz_r;
  logic [15:0] rnd_r;
  logic [SlotW:0] idx_r;
  logic [SlotW-1:0] pick_r, first_r, last_r;
  logic have_first_r;
  logic [37:0] sum_r, cum_r, thr_r;
  logic [49:0] dsq_r;
  logic wstart_r;
  logic [1:0] status_r;
  logic [PointW-1:0] opt_r;
  logic [SlotW-1:0] oslot_r;
  logic out_valid_r;

  logic pt_we, w_we;
  logic [SlotW-1:0] pt_waddr, rd_addr;
  logic [PointW-1:0] pt_rdata;
  logic [31:0] w_rdata, w_val;
  logic w_start, w_done;
  logic signed [24:0] dx_c, dy_c, dz_c;
  logic [49:0] dsq_c;
  logic [SlotW-1:0] free_c;
  logic full_c;
  logic [SlotW-1:0] cur_c;

  assign cur_c = idx_r[SlotW-1:0];
  assign rd_addr = (state_r == S_IDLE || state_r == S_THR) ? pick_r : cur_c;
  assign pt_we = (state_r == S_IDLE) && in_valid && !in_stall
                 && (in_operation == OP_INSERT) && !full_c;
  assign pt_waddr = free_c;
  assign w_we = (state_r == S_WCALC) && w_done;
  // start registered together with the distance, only for a nonzero distance
  assign w_start = wstart_r;

  dwwp_ram #(.Width(PointW), .Depth(MaxPoints)) u_pt (
    .clk(clk), .we(pt_we), .waddr(pt_waddr),
    .wdata({in_pos_x, in_pos_y, in_pos_z}),
    .raddr((state_r == S_FETCH) ? pick_r : rd_addr), .rdata(pt_rdata)
  );
  dwwp_ram #(.Width(32), .Depth(MaxPoints)) u_wt (
    .clk(clk), .we(w_we), .waddr(cur_c), .wdata(w_val),
    .raddr(cur_c), .rdata(w_rdata)
  );
  dwwp_weight u_weight (
    .clk(clk), .rst_n(rst_n), .start(w_start), .dist_sq(dsq_r),
    .degree(degree_r), .done(w_done), .weight(w_val)
  );

  always_comb begin
    free_c = '0;
    full_c = 1'b1;
    for (int i = MaxPoints - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_c = SlotW'(i);
        full_c = 1'b0;
      end
    end
  end

  assign dx_c = 25'(px_r) - 25'(signed'(pt_rdata[71:48]));
  assign dy_c = 25'(py_r) - 25'(signed'(pt_rdata[47:24]));
  assign dz_c = 25'(pz_r) - 25'(signed'(pt_rdata[23:0]));
  assign dsq_c = 50'(dx_c * dx_c) + 50'(dy_c * dy_c) + 50'(dz_c * dz_c);

  assign in_stall = (state_r != S_IDLE) || out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      degree_r <= 8'd16;
      out_valid_r <= 1'b0;
      wstart_r <= 1'b0;
    end else begin
      if (cfg_we) degree_r <= cfg_planning_degree;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      wstart_r <= (state_r == S_WDIST) && (dsq_c != '0);
      case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            px_r <= in_pos_x; py_r <= in_pos_y; pz_r <= in_pos_z;
            rnd_r <= in_random_fraction;
            if (in_operation == OP_INSERT) begin
              out_valid_r <= 1'b1;
              if (full_c) begin
                status_r <= ST_FULL; opt_r <= '0; oslot_r <= '0;
              end else begin
                valid_r[free_c] <= 1'b1;
                status_r <= ST_INSERTED;
                opt_r <= {in_pos_x, in_pos_y, in_pos_z};
                oslot_r <= free_c;
              end
            end else begin
              idx_r <= '0; sum_r <= '0; have_first_r <= 1'b0;
              state_r <= S_WREAD;
            end
          end
        end
        S_WREAD: begin
          if (idx_r == (SlotW+1)'(MaxPoints)) state_r <= S_THR;
          else if (!valid_r[cur_c]) idx_r <= idx_r + 1'b1;
          else state_r <= S_WDIST;
        end
        S_WDIST: begin
          if (!have_first_r) begin first_r <= cur_c; have_first_r <= 1'b1; end
          last_r <= cur_c;
          dsq_r <= dsq_c;
          if (dsq_c == '0) begin
            pick_r <= cur_c; state_r <= S_FETCH;
          end else state_r <= S_WCALC;
        end
        S_WCALC: begin
          if (w_done) begin
            sum_r <= sum_r + 38'(w_val);
            idx_r <= idx_r + 1'b1;
            state_r <= S_WREAD;
          end
        end
        S_THR: begin
          if (!have_first_r) begin
            out_valid_r <= 1'b1; status_r <= ST_EMPTY;
            opt_r <= '0; oslot_r <= '0; state_r <= S_IDLE;
          end else if (sum_r == '0) begin
            pick_r <= first_r; state_r <= S_FETCH;
          end else begin
            thr_r <= 38'((54'(rnd_r) * 54'(sum_r)) >> 16);
            cum_r <= '0; idx_r <= '0; pick_r <= last_r;
            state_r <= S_SREAD;
          end
        end
        S_SREAD: begin
          if (idx_r == (SlotW+1)'(MaxPoints)) state_r <= S_FETCH;
          else if (!valid_r[cur_c]) idx_r <= idx_r + 1'b1;
          else state_r <= S_SACC;
        end
        S_SACC: begin
          if (cum_r + 38'(w_rdata) > thr_r) begin
            pick_r <= cur_c; state_r <= S_FETCH;
          end else begin
            cum_r <= cum_r + 38'(w_rdata);
            idx_r <= idx_r + 1'b1;
            state_r <= S_SREAD;
          end
        end
        S_FETCH: state_r <= S_OUT;
        S_OUT: begin
          valid_r[pick_r] <= 1'b0;
          out_valid_r <= 1'b1;
          status_r <= ST_SELECTED;
          opt_r <= pt_rdata;
          oslot_r <= pick_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = status_r;
  assign out_out_x = opt_r[71:48];
  assign out_out_y = opt_r[47:24];
  assign out_out_z = opt_r[23:0];
  assign out_out_slot = oslot_r;
endmodule
